[hw/rtl/ffha_pkg.sv]
// Shared types and constants for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

   localparam int unsigned HDR_BYTES = 5;
   localparam int unsigned MIN_SPARE = 4;
   localparam int unsigned FIELD_W   = 12;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_WALK,
      ST_ALLOC_SPLIT,
      ST_FREE_WALK,
      ST_MERGE_START,
      ST_MERGE_CUR,
      ST_MERGE_NEXT
   } state_type;

   typedef struct packed {
      logic               operation;
      logic [FIELD_W-1:0] request_size;
      logic [FIELD_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] user_offset;
   } rsp_type;

endpackage
`default_nettype wire

[hw/rtl/ffha_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/first_fit_heap_allocator_unit.sv]
// Top level of the first-fit heap allocator: request sequencer around the header memory.
//
// The arena is kept as a chain of block headers in one memory with one entry per byte
// offset. Every request walks the chain from offset 0, one header per clock through the
// memory read port. An allocate walks up to the first free block that fits, writes its
// header, and, when the block is split, writes the header of the free tail in a further
// step. A free walks the chain to find its block, then makes a merge pass over the whole
// chain from offset 0 that joins adjacent free blocks. busy stays high for that
// whole time and a new request is taken once it falls. The result appears on rsp_data for
// exactly one cycle with rsp_valid, in the cycle busy drops; it is not held, so the
// receiver must take it then. No clearing pass is needed after reset: the root header
// reads as one free block covering the arena until it is first written.
`default_nettype none
module first_fit_heap_allocator_unit #(
   parameter int ARENA_BYTES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire ffha_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output ffha_pkg::rsp_type     rsp_data
);

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;

   typedef struct packed {
      logic          used;
      logic          last;
      logic [AW-1:0] size;
      logic [AW-1:0] next;
   } hdr_type;

   localparam int HW = $bits(hdr_type);

   localparam hdr_type ROOT_HDR = '{
      used: 1'b0,
      last: 1'b1,
      size: AW'(ARENA_BYTES - ffha_pkg::HDR_BYTES),
      next: '0
   };

   ffha_pkg::state_type state_ff, state_in;
   logic [AW-1:0] cur_ff, cur_in;
   hdr_type       hdr_ff, hdr_in;
   logic [ffha_pkg::FIELD_W-1:0] want_ff;
   logic [ffha_pkg::FIELD_W-1:0] uoff_ff;
   logic          root_init_ff, root_init_in;
   logic          rd_root_ff, rd_root_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_type rsp_ff, rsp_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   hdr_type       ram_wr_hdr;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [HW-1:0] ram_rd_data;

   hdr_type       hdr_rd;
   logic          accept;
   logic [CW-1:0] user_ext;
   logic [CW-1:0] spare;
   logic [CW-1:0] nb_ext;
   logic          fit;
   logic          split;
   logic          match;
   logic          both_free;
   hdr_type       merged;
   hdr_type       alloc_hdr;
   hdr_type       tail_hdr;

   ffha_ram #(
      .WIDTH(HW),
      .DEPTH(ARENA_BYTES)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_hdr),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // The root header is virtual until its first write.
   assign hdr_rd = (rd_root_ff && !root_init_ff) ? ROOT_HDR : hdr_type'(ram_rd_data);

   assign accept   = start && (state_ff == ffha_pkg::ST_IDLE);
   assign user_ext = CW'(cur_ff) + CW'(ffha_pkg::HDR_BYTES);
   assign spare    = CW'(hdr_rd.size) - CW'(want_ff);
   assign nb_ext   = user_ext + CW'(want_ff);
   assign fit      = !hdr_rd.used && (CW'(want_ff) <= CW'(hdr_rd.size));
   assign split    = (spare > CW'(ffha_pkg::MIN_SPARE))
                   && (nb_ext + CW'(ffha_pkg::HDR_BYTES) <= CW'(ARENA_BYTES));
   assign match    = hdr_rd.used && (user_ext == CW'(uoff_ff));
   assign both_free = !hdr_ff.used && !hdr_rd.used;

   always_comb begin
      merged      = hdr_rd;
      merged.used = 1'b0;
      merged.size = AW'(CW'(hdr_ff.size) + CW'(ffha_pkg::HDR_BYTES) + CW'(hdr_rd.size));
   end

   always_comb begin
      alloc_hdr      = hdr_rd;
      alloc_hdr.used = 1'b1;
      if (split) begin
         alloc_hdr.size = AW'(want_ff);
         alloc_hdr.last = 1'b0;
         alloc_hdr.next = nb_ext[AW-1:0];
      end
   end

   always_comb begin
      tail_hdr      = hdr_ff;
      tail_hdr.used = 1'b0;
      tail_hdr.size = AW'(CW'(hdr_ff.size) - CW'(want_ff) - CW'(ffha_pkg::HDR_BYTES));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.operation == ffha_pkg::OP_FREE) ?
                          ffha_pkg::ST_FREE_WALK : ffha_pkg::ST_ALLOC_WALK;
            end
         end
         ffha_pkg::ST_ALLOC_WALK: begin
            if (fit) begin
               state_in = split ? ffha_pkg::ST_ALLOC_SPLIT : ffha_pkg::ST_IDLE;
            end else if (hdr_rd.last) begin
               state_in = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_ALLOC_SPLIT: state_in = ffha_pkg::ST_IDLE;
         ffha_pkg::ST_FREE_WALK: begin
            if (match) begin
               state_in = ffha_pkg::ST_MERGE_START;
            end else if (hdr_rd.last) begin
               state_in = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_MERGE_START: state_in = ffha_pkg::ST_MERGE_CUR;
         ffha_pkg::ST_MERGE_CUR: begin
            state_in = hdr_rd.last ? ffha_pkg::ST_IDLE : ffha_pkg::ST_MERGE_NEXT;
         end
         ffha_pkg::ST_MERGE_NEXT: begin
            if (hdr_rd.last) begin
               state_in = ffha_pkg::ST_IDLE;
            end
         end
         default: state_in = ffha_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      cur_in       = cur_ff;
      hdr_in       = hdr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_ff;
      ram_wr_hdr   = hdr_rd;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = hdr_rd.next;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: ffha_pkg::STATUS_OK, user_offset: '0};
      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            if (accept) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               cur_in      = '0;
            end
         end
         ffha_pkg::ST_ALLOC_WALK: begin
            if (fit) begin
               ram_wr_en  = 1'b1;
               ram_wr_hdr = alloc_hdr;
               hdr_in     = hdr_rd;
               if (!split) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.user_offset = user_ext[ffha_pkg::FIELD_W-1:0];
               end
            end else if (hdr_rd.last) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ffha_pkg::STATUS_NO_SPACE;
            end else begin
               ram_rd_en = 1'b1;
               cur_in    = hdr_rd.next;
            end
         end
         ffha_pkg::ST_ALLOC_SPLIT: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = nb_ext[AW-1:0];
            ram_wr_hdr         = tail_hdr;
            rsp_valid_in       = 1'b1;
            rsp_in.user_offset = user_ext[ffha_pkg::FIELD_W-1:0];
         end
         ffha_pkg::ST_FREE_WALK: begin
            if (match) begin
               ram_wr_en       = 1'b1;
               ram_wr_hdr.used = 1'b0;
            end else if (hdr_rd.last) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ffha_pkg::STATUS_BAD_FREE;
            end else begin
               ram_rd_en = 1'b1;
               cur_in    = hdr_rd.next;
            end
         end
         ffha_pkg::ST_MERGE_START: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            cur_in      = '0;
         end
         ffha_pkg::ST_MERGE_CUR: begin
            hdr_in = hdr_rd;
            if (hdr_rd.last) begin
               rsp_valid_in = 1'b1;
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         ffha_pkg::ST_MERGE_NEXT: begin
            // Current header stays in hdr_ff; only the successor comes from memory.
            if (both_free) begin
               ram_wr_en  = 1'b1;
               ram_wr_hdr = merged;
               hdr_in     = merged;
            end else begin
               cur_in = hdr_ff.next;
               hdr_in = hdr_rd;
            end
            if (hdr_rd.last) begin
               rsp_valid_in = 1'b1;
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign root_init_in = root_init_ff || (ram_wr_en && (ram_wr_addr == '0));
   assign rd_root_in   = ram_rd_en ? (ram_rd_addr == '0) : rd_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::ST_IDLE;
         root_init_ff <= 1'b0;
         rd_root_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_init_ff <= root_init_in;
         rd_root_ff   <= rd_root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      hdr_ff <= hdr_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         want_ff <= req_data.request_size;
         uoff_ff <= req_data.free_offset;
      end
   end

   assign busy      = (state_ff != ffha_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a request is still in progress");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start a walk");

   a_fail_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ffha_pkg::STATUS_OK) |-> rsp_data.user_offset == '0)
      else $error("failed request carries a nonzero offset");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> busy)
      else $error("header write outside a request");

   a_split_follows_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffha_pkg::ST_ALLOC_SPLIT) |->
      $past(state_ff) == ffha_pkg::ST_ALLOC_WALK)
      else $error("split entered without an allocate hit");

endmodule
`default_nettype wire
